@@ src/crg_pkg.sv @@
// Shared constants and types for the primary ray generator.
package crg_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COEF_W     = FRAC_BITS + 2;
	localparam int DIM_W      = 13;
	localparam int PIX_W      = 12;
	localparam int MAX_DIM    = 4096;
	localparam int VEC_W      = 15;
	localparam int MAG_W      = 13;
	localparam int SQ_W       = 28;
	localparam int NORM_FRAC  = 16;
	localparam int SQRT_SHIFT = 2 * NORM_FRAC;
	localparam int ROOT_W     = SQ_W / 2 + NORM_FRAC;
	localparam int REM_W      = ROOT_W + 2;
	localparam int DIV_SHIFT  = FRAC_BITS + NORM_FRAC;
	localparam int NUM_W      = MAG_W + DIV_SHIFT + 1;
	localparam int Q_W        = FRAC_BITS + 2;
	localparam int ACC_W      = 2 * COEF_W + 2;
	localparam int SH_W       = ACC_W - FRAC_BITS;
	localparam int CFG_W      = 3 * COEF_W;
	localparam int CFG_IDX_W  = 3;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 56;

	localparam logic [COEF_W-1:0] ONE_COEF = COEF_W'(1 << FRAC_BITS);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_FIRST    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_SECOND   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_THIRD    = 3'd4;

	typedef logic [VEC_W-1:0] vec_t;
	typedef vec_t [2:0] vec3_t;
	typedef logic [Q_W-1:0] quo_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [CFG_W-1:0] row_t;

endpackage

@@ src/crg_vec.sv @@
// Pixel to integer direction vector and its squared length.
module crg_vec import crg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [PIX_W-1:0] pixel_col,
	input  logic [PIX_W-1:0] pixel_row,
	input  logic [DIM_W-1:0] width,
	input  logic [DIM_W-1:0] height,
	output logic             out_valid,
	output vec3_t            out_vec,
	output logic [SQ_W-1:0]  out_sumsq
);

	logic [DIM_W-1:0] w_clip, h_clip;
	vec3_t vec_c;
	logic v_s1, v_s2, v_s3;
	vec3_t vec_s1, vec_s2, vec_s3;
	logic [SQ_W-1:0] sq_s2 [3];
	logic [SQ_W-1:0] sum_s3;

	always_comb begin
		w_clip = (width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width;
		h_clip = (height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height;
		vec_c[0] = VEC_W'({pixel_col, 1'b1}) - VEC_W'(w_clip);
		vec_c[1] = VEC_W'(h_clip) - VEC_W'({pixel_row, 1'b1});
		vec_c[2] = '0 - VEC_W'(h_clip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec_c;
			vec_s2 <= vec_s1;
			vec_s3 <= vec_s2;
			for (int j = 0; j < 3; j++) begin
				sq_s2[j] <= SQ_W'($signed(vec_s1[j]) * $signed(vec_s1[j]));
			end
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	assign out_valid = v_s3;
	assign out_vec   = vec_s3;
	assign out_sumsq = sum_s3;

endmodule

@@ src/crg_sqrt.sv @@
// Pipelined digit-by-digit square root, one result bit per stage.
module crg_sqrt import crg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  vec3_t             in_vec,
	input  logic [SQ_W-1:0]   in_sumsq,
	output logic              out_valid,
	output vec3_t             out_vec,
	output logic [ROOT_W-1:0] out_norm
);

	localparam int TRIAL_W = REM_W + 2;

	logic              v_s    [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SQ_W-1:0]   sq_s   [ROOT_W];
	vec3_t             vec_s  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int PI = ROOT_W - 1 - k;
		logic              v_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SQ_W-1:0]   sq_in;
		vec3_t             vec_in;
		logic [1:0]        pair;
		logic [TRIAL_W-1:0] rem_t, trial;
		logic ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign sq_in   = in_sumsq;
			assign vec_in  = in_vec;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign sq_in   = sq_s[k-1];
			assign vec_in  = vec_s[k-1];
		end

		// radicand is sumsq shifted up; its low pairs are zero
		if (PI >= SQRT_SHIFT / 2) begin : g_pair
			assign pair = sq_in[2*(PI-SQRT_SHIFT/2) +: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign rem_t = {rem_in, pair};
		assign trial = TRIAL_W'({root_in, 2'b01});
		assign ge    = (rem_t >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
				sq_s[k]   <= sq_in;
				vec_s[k]  <= vec_in;
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign out_vec   = vec_s[ROOT_W-1];
	assign out_norm  = root_s[ROOT_W-1];

endmodule

@@ src/crg_div.sv @@
// Three-lane pipelined restoring divider: |v| scaled, rounded, over the norm.
module crg_div import crg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  vec3_t             in_vec,
	input  logic [ROOT_W-1:0] in_norm,
	output logic              out_valid,
	output quo_t              out_quo [3],
	output logic [2:0]        out_neg
);

	localparam int CMP_W = NUM_W + 2;

	logic              v_s0;
	logic [NUM_W-1:0]  rem_s0 [3];
	logic [ROOT_W-1:0] norm_s0;
	logic [2:0]        neg_s0;

	logic              v_s    [Q_W];
	logic [NUM_W-1:0]  rem_s  [Q_W][3];
	quo_t              quo_s  [Q_W][3];
	logic [ROOT_W-1:0] norm_s [Q_W];
	logic [2:0]        neg_s  [Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
		end
	end

	// numerator = |v| << shift plus half the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			norm_s0 <= in_norm;
			for (int l = 0; l < 3; l++) begin
				neg_s0[l] <= in_vec[l][VEC_W-1];
				rem_s0[l] <= NUM_W'({MAG_W'(in_vec[l][VEC_W-1] ? ('0 - in_vec[l]) : in_vec[l]),
					{DIV_SHIFT{1'b0}}}) + NUM_W'(in_norm >> 1);
			end
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		localparam int BI = Q_W - 1 - k;
		logic              v_in;
		logic [ROOT_W-1:0] norm_in;
		logic [2:0]        neg_in;
		logic [CMP_W-1:0]  dsh;

		if (k == 0) begin : g_first
			assign v_in    = v_s0;
			assign norm_in = norm_s0;
			assign neg_in  = neg_s0;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign norm_in = norm_s[k-1];
			assign neg_in  = neg_s[k-1];
		end

		assign dsh = CMP_W'(norm_in) << BI;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				norm_s[k] <= norm_in;
				neg_s[k]  <= neg_in;
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [NUM_W-1:0] rem_in;
			quo_t             quo_in;
			logic [CMP_W-1:0] rem_x;
			logic             ge;

			if (k == 0) begin : g_first
				assign rem_in = rem_s0[l];
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[k-1][l];
				assign quo_in = quo_s[k-1][l];
			end

			assign rem_x = CMP_W'(rem_in);
			assign ge    = (rem_x >= dsh);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? NUM_W'(rem_x - dsh) : rem_in;
					quo_s[k][l] <= {quo_in[Q_W-2:0], ge};
				end
			end
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign out_neg   = neg_s[Q_W-1];
	for (genvar l = 0; l < 3; l++) begin : g_out
		assign out_quo[l] = quo_s[Q_W-1][l];
	end

endmodule

@@ src/crg_mat.sv @@
// Unit vector clamp/sign, 3x3 rotation, rounding and saturation.
module crg_mat import crg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  quo_t       in_quo [3],
	input  logic [2:0] in_neg,
	input  row_t       rot [3],
	output logic       out_valid,
	output coef_t      out_dir [3]
);

	localparam logic signed [SH_W-1:0]  SAT_HI = SH_W'(ONE_COEF);
	localparam logic signed [SH_W-1:0]  SAT_LO = -SAT_HI;
	localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(1 << (FRAC_BITS - 1));

	logic v_s1, v_s2, v_s3, v_s4;
	coef_t u_s1 [3];
	logic signed [2*COEF_W-1:0] prod_s2 [3][3];
	logic signed [SH_W-1:0] rnd_s3 [3];
	coef_t dir_s4 [3];

	logic [Q_W-1:0] mag_c [3];
	logic signed [ACC_W-1:0] acc_c [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			mag_c[l] = (in_quo[l] > ONE_COEF) ? ONE_COEF : in_quo[l];
		end
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = ACC_W'(prod_s2[i][0]) + ACC_W'(prod_s2[i][1]) +
				ACC_W'(prod_s2[i][2]) + ROUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				u_s1[l] <= in_neg[l] ? coef_t'('0 - mag_c[l]) : coef_t'(mag_c[l]);
			end
			// x coefficient sits in the top field of each row
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= $signed(rot[i][(2-j)*COEF_W +: COEF_W]) * u_s1[j];
				end
			end
			for (int i = 0; i < 3; i++) begin
				rnd_s3[i] <= SH_W'(acc_c[i] >>> FRAC_BITS);
			end
			for (int i = 0; i < 3; i++) begin
				if (rnd_s3[i] > SAT_HI) begin
					dir_s4[i] <= coef_t'(SAT_HI);
				end else if (rnd_s3[i] < SAT_LO) begin
					dir_s4[i] <= coef_t'(SAT_LO);
				end else begin
					dir_s4[i] <= coef_t'(rnd_s3[i]);
				end
			end
		end
	end

	assign out_valid = v_s4;
	assign out_dir   = dir_s4;

endmodule

@@ src/camera_primary_ray_generator_unit.sv @@
// Pinhole camera primary ray generator: pixel in, rotated unit ray direction out.
// One pixel (column, row) transaction produces one transaction carrying the world-space
// unit direction of the ray through the pixel center, as three signed Q1.16 values.
// A new pixel is taken every clock cycle unless the output stalls; the pipeline runs
// through the vector and its squared length, the bit-per-stage square root, the three-lane
// divider, then rotation and rounding. When the output transaction is not taken the
// whole pipeline holds, so s_tready follows m_tready combinationally while m_tvalid is
// high. Configuration may only be written while no pixel is in flight. Width and height
// above 4096 act as 4096; results saturate to +/-1.0 for a non-orthonormal matrix.
module camera_primary_ray_generator_unit import crg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// pixel stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // pixel_col[11:0], pixel_row[23:12]
	// ray direction stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // dir_x[17:0], dir_y[35:18], dir_z[53:36], zero pad
);

	logic [DIM_W-1:0] width_q, height_q;
	row_t rot_q [3];

	// global pipeline advance: the output register is the last stage
	logic en;

	logic              vec_valid;
	vec3_t             vec_vec;
	logic [SQ_W-1:0]   vec_sumsq;
	logic              sqrt_valid;
	vec3_t             sqrt_vec;
	logic [ROOT_W-1:0] sqrt_norm;
	logic              div_valid;
	quo_t              div_quo [3];
	logic [2:0]        div_neg;
	coef_t             dir [3];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// configuration registers, reset to 640x480 and identity rotation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
			rot_q[0] <= {ONE_COEF, {COEF_W{1'b0}}, {COEF_W{1'b0}}};
			rot_q[1] <= {{COEF_W{1'b0}}, ONE_COEF, {COEF_W{1'b0}}};
			rot_q[2] <= {{COEF_W{1'b0}}, {COEF_W{1'b0}}, ONE_COEF};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_ROT_FIRST:    rot_q[0] <= cfg_data;
				REG_ROT_SECOND:   rot_q[1] <= cfg_data;
				REG_ROT_THIRD:    rot_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	crg_vec u_vec (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.pixel_col (s_tdata[PIX_W-1:0]),
		.pixel_row (s_tdata[2*PIX_W-1:PIX_W]),
		.width     (width_q),
		.height    (height_q),
		.out_valid (vec_valid),
		.out_vec   (vec_vec),
		.out_sumsq (vec_sumsq)
	);

	crg_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vec_valid),
		.in_vec    (vec_vec),
		.in_sumsq  (vec_sumsq),
		.out_valid (sqrt_valid),
		.out_vec   (sqrt_vec),
		.out_norm  (sqrt_norm)
	);

	crg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sqrt_valid),
		.in_vec    (sqrt_vec),
		.in_norm   (sqrt_norm),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_neg   (div_neg)
	);

	crg_mat u_mat (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.in_quo    (div_quo),
		.in_neg    (div_neg),
		.rot       (rot_q),
		.out_valid (m_tvalid),
		.out_dir   (dir)
	);

	assign m_tdata = {{(OUT_DATA_W - 3*COEF_W){1'b0}}, dir[2], dir[1], dir[0]};

`ifndef SYNTHESIS
	// a held result must freeze the input side
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while output stalled");

	// saturation keeps every component within +/-1.0
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (dir[0] <= $signed(ONE_COEF)) && (dir[0] >= -$signed(ONE_COEF)) &&
			(dir[1] <= $signed(ONE_COEF)) && (dir[1] >= -$signed(ONE_COEF)) &&
			(dir[2] <= $signed(ONE_COEF)) && (dir[2] >= -$signed(ONE_COEF)))
		else $error("ray direction out of range");

	// a valid result stays put until taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");
`endif

endmodule
